### hw/rtl/sgpd_pkg.sv
// Shared constants, types and lookup functions for the servo gait PWM duty block.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none
package sgpd_pkg;

  localparam int PosMax     = 180;
  localparam int PulseMinUs = 500;
  localparam int PulseMaxUs = 2500;
  localparam int DutyBits   = 14;
  localparam int PeriodUs   = 20000;
  localparam int DutyMax    = 16383;

  localparam int NumServos  = 4;
  localparam int NumRegs    = 8;

  // Pulse span over position is 2000/180 = 100/9: multiply by 100*ceil(2^17/9),
  // keep bits 28:17. Exact for every position up to PosMax.
  localparam logic [20:0] PulseMul = 21'd1456400;
  // Duty is pulse*2^14/20000 = pulse*512/625: multiply by ceil(2^30/625),
  // keep bits 32:21. Exact for every pulse up to PulseMaxUs.
  localparam logic [20:0] DutyMul  = 21'd1717987;

  localparam logic [1:0] SERVO_LEFT_FOOT  = 2'd0;
  localparam logic [1:0] SERVO_RIGHT_FOOT = 2'd1;
  localparam logic [1:0] SERVO_LEFT_HAND  = 2'd2;
  localparam logic [1:0] SERVO_RIGHT_HAND = 2'd3;

  localparam logic OP_GAIT   = 1'b0;
  localparam logic OP_CENTER = 1'b1;

  // Stage-0 beat: one servo of one item.
  typedef struct packed {
    logic       to_center;
    logic [1:0] servo;
    logic [7:0] rom_addr;
    logic       negate;
    logic [7:0] center;
    logic [7:0] swing;
  } sgpd_job_t;

  // Sine ROM, peak 256 (10-bit signed).
  function automatic logic signed [9:0] sine_rom(input logic [7:0] addr);
    logic [7:0] q;
    logic [8:0] mag;
    q = addr[6] ? 8'(8'd128 - {1'b0, addr[6:0]}) : {1'b0, addr[6:0]};
    // q in 0..64: first quarter lookup
    case (q)
      8'd0:  mag = 9'd0;   8'd1:  mag = 9'd6;   8'd2:  mag = 9'd12;  8'd3:  mag = 9'd18;
      8'd4:  mag = 9'd25;  8'd5:  mag = 9'd31;  8'd6:  mag = 9'd37;  8'd7:  mag = 9'd43;
      8'd8:  mag = 9'd49;  8'd9:  mag = 9'd55;  8'd10: mag = 9'd62;  8'd11: mag = 9'd68;
      8'd12: mag = 9'd74;  8'd13: mag = 9'd80;  8'd14: mag = 9'd86;  8'd15: mag = 9'd92;
      8'd16: mag = 9'd98;  8'd17: mag = 9'd104; 8'd18: mag = 9'd109; 8'd19: mag = 9'd115;
      8'd20: mag = 9'd121; 8'd21: mag = 9'd126; 8'd22: mag = 9'd132; 8'd23: mag = 9'd137;
      8'd24: mag = 9'd142; 8'd25: mag = 9'd147; 8'd26: mag = 9'd152; 8'd27: mag = 9'd157;
      8'd28: mag = 9'd162; 8'd29: mag = 9'd167; 8'd30: mag = 9'd171; 8'd31: mag = 9'd176;
      8'd32: mag = 9'd180; 8'd33: mag = 9'd184; 8'd34: mag = 9'd189; 8'd35: mag = 9'd193;
      8'd36: mag = 9'd197; 8'd37: mag = 9'd201; 8'd38: mag = 9'd205; 8'd39: mag = 9'd208;
      8'd40: mag = 9'd212; 8'd41: mag = 9'd215; 8'd42: mag = 9'd219; 8'd43: mag = 9'd222;
      8'd44: mag = 9'd225; 8'd45: mag = 9'd228; 8'd46: mag = 9'd231; 8'd47: mag = 9'd233;
      8'd48: mag = 9'd236; 8'd49: mag = 9'd238; 8'd50: mag = 9'd241; 8'd51: mag = 9'd243;
      8'd52: mag = 9'd244; 8'd53: mag = 9'd246; 8'd54: mag = 9'd248; 8'd55: mag = 9'd249;
      8'd56: mag = 9'd251; 8'd57: mag = 9'd252; 8'd58: mag = 9'd253; 8'd59: mag = 9'd254;
      8'd60: mag = 9'd254; 8'd61: mag = 9'd255; 8'd62: mag = 9'd255; 8'd63: mag = 9'd255;
      8'd64: mag = 9'd256;
      default: mag = 9'd0;
    endcase
    sine_rom = addr[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sgpd_seq.sv
// Sequencer: holds one input item and issues four servo beats with their registers.
// Depends on sgpd_pkg.
`default_nettype none
module sgpd_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 op,
  input  wire logic [7:0]           gait_phase,
  input  wire logic [7:0]           centers [4],
  input  wire logic [7:0]           swings [4],
  output logic                      job_valid,
  output sgpd_pkg::sgpd_job_t       job,
  input  wire logic                 job_stall
);
  import sgpd_pkg::*;

  logic       busy;
  logic [1:0] cnt;
  logic       hold_op;
  logic [7:0] hold_phase;

  assign job_valid = busy;
  // Take the next item as the fourth beat leaves.
  assign in_stall  = busy && !(!job_stall && cnt == SERVO_RIGHT_HAND);

  always_comb begin
    job.to_center = hold_op == OP_CENTER;
    job.servo     = cnt;
    job.rom_addr  = hold_phase + ((cnt == SERVO_RIGHT_FOOT || cnt == SERVO_LEFT_HAND)
                    ? 8'd128 : 8'd0);
    job.negate    = cnt == SERVO_LEFT_FOOT || cnt == SERVO_LEFT_HAND;
    job.center    = centers[cnt];
    job.swing     = swings[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (in_valid && !in_stall) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy && !job_stall) begin
        cnt <= cnt + 2'd1;
        if (cnt == SERVO_RIGHT_HAND) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_op    <= op;
      hold_phase <= gait_phase;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/sgpd_pipe.sv
// Datapath pipeline: sine lookup, multiply, scale and clamp, pulse width, duty.
// Depends on sgpd_pkg.
`default_nettype none
module sgpd_pipe (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 job_valid,
  output logic                      job_stall,
  input  wire sgpd_pkg::sgpd_job_t  job,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                servo_index,
  output logic [7:0]                servo_position,
  output logic [13:0]               pwm_duty,
  output logic                      last_servo
);
  import sgpd_pkg::*;

  // Stage 1: wave
  logic              v1;
  logic              c1;
  logic [1:0]        s1;
  logic [7:0]        ctr1;
  logic [7:0]        sw1;
  logic signed [9:0] w1;
  // Stage 2: product
  logic              v2;
  logic              c2;
  logic [1:0]        s2;
  logic [7:0]        ctr2;
  logic signed [18:0] p2;
  // Stage 3: position
  logic              v3;
  logic [1:0]        s3;
  logic [7:0]        pos3;
  // Stage 4: pulse width
  logic              v4;
  logic [1:0]        s4;
  logic [7:0]        pos4;
  logic [11:0]       pulse4;

  logic              adv1, adv2, adv3, adv4, adv5;
  logic signed [9:0] wave;
  logic signed [18:0] prod;
  logic signed [10:0] q2;
  logic signed [11:0] sum2;
  logic [7:0]        pos_next;
  logic [7:0]        cen_cl;
  logic [28:0]       pulse_prod;
  logic [11:0]       pulse_next;
  logic [32:0]       duty_prod;

  assign adv5 = !out_valid || !out_stall;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign job_stall = !adv1;

  always_comb begin
    wave = sine_rom(job.rom_addr);
    if (job.negate) wave = -wave;
    prod = w1 * $signed({1'b0, sw1});
    // Truncate toward zero: bias negatives by 255 before the shift.
    q2   = 11'((p2 + (p2[18] ? 19'sd255 : 19'sd0)) >>> 8);
    sum2 = $signed({4'd0, ctr2}) + 12'(q2);
    cen_cl = (ctr2 > 8'(PosMax)) ? 8'(PosMax) : ctr2;
    if (c2)                       pos_next = cen_cl;
    else if (sum2 < 0)            pos_next = 8'd0;
    else if (sum2 > 12'sd180)     pos_next = 8'(PosMax);
    else                          pos_next = sum2[7:0];
    pulse_prod = pos3 * PulseMul;
    pulse_next = 12'(PulseMinUs) + pulse_prod[28:17];
    duty_prod  = pulse4 * DutyMul;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= job_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      c1 <= job.to_center; s1 <= job.servo; ctr1 <= job.center;
      sw1 <= job.swing; w1 <= wave;
    end
    if (adv2) begin
      c2 <= c1; s2 <= s1; ctr2 <= ctr1; p2 <= prod;
    end
    if (adv3) begin
      s3 <= s2; pos3 <= pos_next;
    end
    if (adv4) begin
      s4 <= s3; pos4 <= pos3; pulse4 <= pulse_next;
    end
    if (adv5) begin
      servo_index    <= s4;
      servo_position <= pos4;
      // Duty tops out at 2048 here, well inside the field.
      pwm_duty       <= {2'b00, duty_prod[32:21]};
      last_servo     <= s4 == SERVO_RIGHT_HAND;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/servo_gait_pwm_duty_top.sv
// Servo gait PWM duty: top level with register file, sequencer and datapath.
// Depends on sgpd_pkg, sgpd_seq and sgpd_pipe.
//
// Use: an input beat (op, gait_phase) is taken when in_valid is high and
// in_stall low. Each beat yields four result beats, servo 0..3 in order,
// the fourth with last_servo set, taken when out_valid is high and
// out_stall low. Registers are written over cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, indexes 0..3 select
// centres and 4..7 swings. Write them only while the block is idle.
// Throughput: one result per cycle while out_stall is low, set by
// the sequencer issuing one servo per cycle into the datapath.
// Pipeline: a result passes the sequencer hold, wave, product, position,
// pulse and duty stages in order.
// Reset clears all valids and loads centres 90 and swings 30.
// A stall on the result side freezes every occupied stage; nothing is lost.
`default_nettype none
module servo_gait_pwm_duty_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  gait_phase,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       servo_index,
  output logic [7:0]       servo_position,
  output logic [13:0]      pwm_duty,
  output logic             last_servo,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import sgpd_pkg::*;

  logic [7:0] centers [4];
  logic [7:0] swings [4];
  logic       job_valid;
  logic       job_stall;
  sgpd_job_t  job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumServos; i++) begin
        centers[i] <= 8'd90;
        swings[i]  <= 8'd30;
      end
    end else if (cfg_valid) begin
      if (cfg_index[2]) swings[cfg_index[1:0]]  <= cfg_data;
      else              centers[cfg_index[1:0]] <= cfg_data;
    end
  end

  sgpd_seq u_seq (
    .clk, .rst, .in_valid, .in_stall, .op, .gait_phase,
    .centers, .swings, .job_valid, .job, .job_stall
  );

  sgpd_pipe u_pipe (
    .clk, .rst, .job_valid, .job_stall, .job,
    .out_valid, .out_stall, .servo_index, .servo_position, .pwm_duty, .last_servo
  );
endmodule
`default_nettype wire
